// File: hw/rtl/roi_mean_fringe_counter_core_macros.svh
// ----------------------------------------------------------------------------
// roi_mean_fringe_counter_core_macros - assertion macros
// Concurrent check wrappers clocked on i_clk, disabled while i_rst_n is low.
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ROI_MEAN_FRINGE_COUNTER_CORE_MACROS_SVH
`define ROI_MEAN_FRINGE_COUNTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define RMFC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RMFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RMFC_ASSERT_IMPL(lbl, ante, cons, msg)
`define RMFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/rmfc_pkg.sv
// ----------------------------------------------------------------------------
// rmfc_pkg - shared types and constants
// Register indexes, opcodes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package rmfc_pkg;

    localparam int SUM_W  = 20;             // region sum
    localparam int FRAC_W = 8;              // 8.8 mean
    localparam int DIVD_W = SUM_W + FRAC_W; // dividend
    localparam int SIZE_W = 7;              // roi side length
    localparam int DIVS_W = 2 * SIZE_W;     // side squared
    localparam int CNT_W  = 16;
    localparam int COORD_W = 12;

    localparam logic [SIZE_W-1:0] DEFAULT_ROI_SIZE = 7'd20;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [2:0] REG_ROI_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_ROI_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_ROI_SIZE       = 3'd2;
    localparam logic [2:0] REG_THRESHOLD_LOW  = 3'd3;
    localparam logic [2:0] REG_THRESHOLD_HIGH = 3'd4;
    localparam logic [2:0] REG_FIRST_FRAME    = 3'd5;
    localparam logic [2:0] REG_STOP_FRAME     = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] roi_center_x;
        logic [COORD_W-1:0] roi_center_y;
        logic [SIZE_W-1:0]  roi_size;
        logic [15:0]        threshold_low;
        logic [15:0]        threshold_high;
        logic [15:0]        first_frame;
        logic [16:0]        stop_frame;     // two's complement
    } t_cfg;

    typedef struct packed {
        logic accum;      // pixel transfer, add if inside ROI
        logic clear;      // clear transfer
        logic start_div;  // launch mean division
        logic emit;       // load result register, update counters
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/rmfc_div.sv
// ----------------------------------------------------------------------------
// rmfc_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmfc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rmfc_pkg::DIVD_W-1:0] i_dividend,
    input  logic [rmfc_pkg::DIVS_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [rmfc_pkg::DIVD_W-1:0] o_quot
);

    localparam int DW = rmfc_pkg::DIVD_W;
    localparam int SW = rmfc_pkg::DIVS_W;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LastStep = CW'(DW - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quot;   // dividend shifts out, quotient shifts in
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_divisor;

    logic [SW:0]   w_shift;
    logic [SW:0]   w_diff;
    logic          w_ge;

    always_comb begin
        w_shift = {r_rem, r_quot[DW-1]};
        w_diff  = w_shift - {1'b0, r_divisor};
        w_ge    = (w_shift >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the low bits suffice
            r_rem  <= w_ge ? w_diff[SW-1:0] : w_shift[SW-1:0];
            r_quot <= {r_quot[DW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: hw/rtl/rmfc_ctrl.sv
// ----------------------------------------------------------------------------
// rmfc_ctrl - frame controller
// Takes pixel and clear transfers while idle; on an end-of-frame pixel runs the divide and emits one result.
// ----------------------------------------------------------------------------
module rmfc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_clear,
    input  logic              i_in_last,
    input  rmfc_pkg::t_status i_status,
    output logic              o_in_ready,
    output rmfc_pkg::t_cmd    o_cmd
);

    rmfc_pkg::t_state r_state;
    rmfc_pkg::t_state n_state;
    logic             w_accept;

    assign w_accept = i_in_valid && (r_state == rmfc_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmfc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rmfc_pkg::ST_IDLE: begin
                if (w_accept && (i_in_clear == rmfc_pkg::OP_PIXEL) && i_in_last) begin
                    n_state = rmfc_pkg::ST_START;
                end
            end
            rmfc_pkg::ST_START: begin
                n_state = rmfc_pkg::ST_DIV;
            end
            rmfc_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = rmfc_pkg::ST_EMIT;
                end
            end
            rmfc_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = rmfc_pkg::ST_IDLE;
                end
            end
            default: n_state = rmfc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == rmfc_pkg::ST_IDLE);
        o_cmd.clear     = w_accept && (i_in_clear == rmfc_pkg::OP_CLEAR);
        o_cmd.accum     = w_accept && (i_in_clear == rmfc_pkg::OP_PIXEL);
        o_cmd.start_div = (r_state == rmfc_pkg::ST_START);
        o_cmd.emit      = (r_state == rmfc_pkg::ST_EMIT) && i_status.out_free;
    end

endmodule

// File: hw/rtl/rmfc_dp.sv
// ----------------------------------------------------------------------------
// rmfc_dp - ROI accumulator, mean divider and hysteresis counter
// Holds the region sum, frame and crossing counters and the result register.
// ----------------------------------------------------------------------------
module rmfc_dp #(
    parameter int MAX_ROI_SIZE = 64,
    parameter int FRAME_DIM    = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rmfc_pkg::t_cfg               i_cfg,
    input  rmfc_pkg::t_cmd               i_cmd,
    input  logic [7:0]                   i_pix_value,
    input  logic [rmfc_pkg::COORD_W-1:0] i_pix_x,
    input  logic [rmfc_pkg::COORD_W-1:0] i_pix_y,
    input  logic                         i_out_ready,
    output rmfc_pkg::t_status            o_status,
    output logic                         o_out_valid,
    output logic [15:0]                  o_frame_index,
    output logic [15:0]                  o_frame_mean,
    output logic [15:0]                  o_fringe_count,
    output logic                         o_in_window
);

    localparam int SZW = rmfc_pkg::SIZE_W;
    localparam int SMW = rmfc_pkg::SUM_W;
    localparam int CW  = rmfc_pkg::CNT_W;
    localparam logic [8:0]  MaxSize  = 9'(MAX_ROI_SIZE);
    localparam logic [14:0] FrameDim = 15'(FRAME_DIM);

    logic [SMW-1:0] r_sum;
    logic [CW-1:0]  r_frame_cnt;
    logic [CW-1:0]  r_cross;
    logic           r_armed;
    logic           r_below;
    logic           r_out_valid;
    logic [15:0]    r_out_index;
    logic [15:0]    r_out_mean;
    logic [15:0]    r_out_count;
    logic           r_out_win;

    logic [CW-1:0]  n_cross;
    logic           n_armed;
    logic           n_below;

    logic [SZW-1:0]             w_size_raw;
    logic [SZW-1:0]             w_size;
    logic signed [13:0]         w_left;
    logic signed [13:0]         w_top;
    logic signed [13:0]         w_px;
    logic signed [13:0]         w_py;
    logic                       w_inside;
    logic [SMW:0]               w_sum_add;
    logic [rmfc_pkg::DIVS_W-1:0] w_sq;
    logic                       w_div_done;
    logic [rmfc_pkg::DIVD_W-1:0] w_quot;
    logic [15:0]                w_mean;
    logic signed [16:0]         w_first_s;
    logic signed [16:0]         w_idx_s;
    logic signed [16:0]         w_stop;
    logic                       w_win;

    // effective side length: zero means default, then clamp
    always_comb begin
        w_size_raw = (i_cfg.roi_size == '0) ? rmfc_pkg::DEFAULT_ROI_SIZE : i_cfg.roi_size;
        w_size     = ({2'b00, w_size_raw} > MaxSize) ? MaxSize[SZW-1:0] : w_size_raw;
        w_sq       = {7'b0, w_size} * {7'b0, w_size};
    end

    always_comb begin
        w_left = $signed({2'b00, i_cfg.roi_center_x}) - $signed({8'b0, w_size[SZW-1:1]});
        w_top  = $signed({2'b00, i_cfg.roi_center_y}) - $signed({8'b0, w_size[SZW-1:1]});
        w_px   = $signed({2'b00, i_pix_x});
        w_py   = $signed({2'b00, i_pix_y});
        w_inside = ({3'b000, i_pix_x} < FrameDim) && ({3'b000, i_pix_y} < FrameDim) &&
                   (w_px >= w_left) && (w_px < w_left + $signed({7'b0, w_size})) &&
                   (w_py >= w_top)  && (w_py < w_top  + $signed({7'b0, w_size}));
        w_sum_add = {1'b0, r_sum} + {13'b0, i_pix_value};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.start_div) begin
            r_sum <= '0;
        end else if (i_cmd.accum && w_inside) begin
            r_sum <= w_sum_add[SMW] ? '1 : w_sum_add[SMW-1:0];
        end
    end

    rmfc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend ({r_sum, {rmfc_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (w_sq),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // counting window and hysteresis for the finished frame
    always_comb begin
        w_mean    = (|w_quot[rmfc_pkg::DIVD_W-1:16]) ? 16'hFFFF : w_quot[15:0];
        w_first_s = $signed({1'b0, i_cfg.first_frame});
        w_idx_s   = $signed({1'b0, r_frame_cnt});
        w_stop    = $signed(i_cfg.stop_frame);
        w_win     = (r_frame_cnt >= i_cfg.first_frame) &&
                    ((w_stop < w_first_s) || (w_idx_s < w_stop));
        n_cross = r_cross;
        n_armed = r_armed;
        n_below = r_below;
        if (w_win) begin
            if (w_mean < i_cfg.threshold_low) begin
                n_armed = 1'b1;
                n_below = 1'b1;
            end else if (w_mean > i_cfg.threshold_high) begin
                if (r_armed && r_below && (r_cross != '1)) begin
                    n_cross = r_cross + 1'b1;
                end
                n_armed = 1'b1;
                n_below = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cnt <= '0;
            r_cross     <= '0;
            r_armed     <= 1'b0;
            r_below     <= 1'b0;
        end else if (i_cmd.clear) begin
            r_frame_cnt <= '0;
            r_cross     <= '0;
            r_armed     <= 1'b0;
            r_below     <= 1'b0;
        end else if (i_cmd.emit) begin
            if (r_frame_cnt != '1) begin
                r_frame_cnt <= r_frame_cnt + 1'b1;
            end
            r_cross <= n_cross;
            r_armed <= n_armed;
            r_below <= n_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_index <= r_frame_cnt;
            r_out_mean  <= w_mean;
            r_out_count <= n_cross;
            r_out_win   <= w_win;
        end
    end

    always_comb begin
        o_status.div_done = w_div_done;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_index  = r_out_index;
    assign o_frame_mean   = r_out_mean;
    assign o_fringe_count = r_out_count;
    assign o_in_window    = r_out_win;

endmodule

// File: hw/rtl/roi_mean_fringe_counter_core.sv
// ----------------------------------------------------------------------------
// roi_mean_fringe_counter_core - ROI frame mean with hysteresis fringe counter
// Pixel and clear transfers: one per cycle while idle; in-ROI pixels summed the cycle they land.
// End of frame: the input stalls through START, the 28-step restoring divide (DIV) and EMIT,
// which loads the result once the output register is free. Reset: sync active-low.
// ----------------------------------------------------------------------------
`include "roi_mean_fringe_counter_core_macros.svh"

module roi_mean_fringe_counter_core #(
    parameter int MAX_ROI_SIZE = 64,
    parameter int FRAME_DIM    = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pixel_value[7:0], pixel_x[19:8], pixel_y[31:20]
    input  logic [0:0]  s_axis_tuser,   // opcode[0]
    input  logic        s_axis_tlast,   // end_of_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // frame_index[15:0], frame_mean[31:16],
                                        // fringe_count[47:32], in_window[48], zero pad
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    rmfc_pkg::t_cfg    r_cfg;
    rmfc_pkg::t_cmd    w_cmd;
    rmfc_pkg::t_status w_status;
    logic [15:0]       w_frame_index;
    logic [15:0]       w_frame_mean;
    logic [15:0]       w_fringe_count;
    logic              w_in_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.roi_center_x   <= '0;
            r_cfg.roi_center_y   <= '0;
            r_cfg.roi_size       <= rmfc_pkg::DEFAULT_ROI_SIZE;
            r_cfg.threshold_low  <= '0;
            r_cfg.threshold_high <= '1;
            r_cfg.first_frame    <= '0;
            r_cfg.stop_frame     <= '1;   // -1
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rmfc_pkg::REG_ROI_CENTER_X:   r_cfg.roi_center_x   <= i_cfg_data[11:0];
                rmfc_pkg::REG_ROI_CENTER_Y:   r_cfg.roi_center_y   <= i_cfg_data[11:0];
                rmfc_pkg::REG_ROI_SIZE:       r_cfg.roi_size       <= i_cfg_data[6:0];
                rmfc_pkg::REG_THRESHOLD_LOW:  r_cfg.threshold_low  <= i_cfg_data[15:0];
                rmfc_pkg::REG_THRESHOLD_HIGH: r_cfg.threshold_high <= i_cfg_data[15:0];
                rmfc_pkg::REG_FIRST_FRAME:    r_cfg.first_frame    <= i_cfg_data[15:0];
                rmfc_pkg::REG_STOP_FRAME:     r_cfg.stop_frame     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rmfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_clear (s_axis_tuser[0]),
        .i_in_last  (s_axis_tlast),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    rmfc_dp #(
        .MAX_ROI_SIZE (MAX_ROI_SIZE),
        .FRAME_DIM    (FRAME_DIM)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd          (w_cmd),
        .i_pix_value    (s_axis_tdata[7:0]),
        .i_pix_x        (s_axis_tdata[19:8]),
        .i_pix_y        (s_axis_tdata[31:20]),
        .i_out_ready    (m_axis_tready),
        .o_status       (w_status),
        .o_out_valid    (m_axis_tvalid),
        .o_frame_index  (w_frame_index),
        .o_frame_mean   (w_frame_mean),
        .o_fringe_count (w_fringe_count),
        .o_in_window    (w_in_window)
    );

    assign m_axis_tdata = {7'b0, w_in_window, w_fringe_count, w_frame_mean, w_frame_index};

    // result register must be free whenever a result is loaded
    `RMFC_ASSERT_IMPL(a_emit_needs_room, w_cmd.emit, w_status.out_free, "emit into full output")
    // a loaded result is presented on the next cycle
    `RMFC_ASSERT_NEXT(a_emit_shows, w_cmd.emit, m_axis_tvalid, "emitted result not valid")
    // the end-of-frame pixel parks the input while the mean is computed
    `RMFC_ASSERT_NEXT(a_eof_stalls,
        s_axis_tvalid && s_axis_tready && s_axis_tlast && !s_axis_tuser[0],
        !s_axis_tready, "input not stalled after end of frame")
    // division start and result load never coincide with an input transfer
    `RMFC_ASSERT_IMPL(a_busy_no_accept, w_cmd.start_div || w_cmd.emit,
        !s_axis_tready, "input ready while frame result pending")

endmodule
